// ===== rtl/core/bcdcal_pkg.sv =====
// shared types, constants and bcd helper functions for the bcd calendar clock
// no dependencies
`default_nettype none

package bcdcal_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  // one complete date and time, all fields bcd except the binary weekday
  typedef struct packed {
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } cal_t;

  localparam logic [7:0] YearMax   = 8'h99;
  localparam logic [7:0] YearMin   = 8'h00;
  localparam logic [7:0] MonthMin  = 8'h01;
  localparam logic [7:0] MonthMax  = 8'h12;
  localparam logic [7:0] DayMin    = 8'h01;
  localparam logic [7:0] WdayMin   = 8'h00;
  localparam logic [7:0] WdayMax   = 8'h06;
  localparam logic [7:0] HourMin   = 8'h00;
  localparam logic [7:0] HourMax   = 8'h23;
  localparam logic [7:0] MinSecMin = 8'h00;
  localparam logic [7:0] MinSecMax = 8'h59;

  localparam cal_t CalReset = '{
    year:    8'h00,
    month:   5'h01,
    day:     6'h01,
    weekday: 3'd0,
    hour:    6'h00,
    minute:  7'h00,
    second:  7'h00
  };

  // clamp a raw bcd byte into [lo, hi]; a bad nibble gives hi
  // for valid bcd the plain unsigned order matches the decimal order
  function automatic logic [7:0] bcd_clamp(input logic [7:0] raw,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic [7:0] res;
    if (raw[7:4] > 4'd9 || raw[3:0] > 4'd9) begin
      res = hi;
    end else if (raw < lo) begin
      res = lo;
    end else if (raw > hi) begin
      res = hi;
    end else begin
      res = raw;
    end
    return res;
  endfunction

  // increment a valid bcd byte that is below its field maximum
  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] res;
    if (v[3:0] == 4'd9) begin
      res = {v[7:4] + 4'd1, 4'h0};
    end else begin
      res = {v[7:4], v[3:0] + 4'd1};
    end
    return res;
  endfunction

  // month length in bcd; bcd year divisible by 4 iff (2*tens + units) mod 4 is 0
  function automatic logic [5:0] month_days(input logic [7:0] year,
                                            input logic [4:0] month);
    logic [1:0] yr_mod;
    logic [5:0] res;
    yr_mod = year[1:0] + {year[4], 1'b0};
    case (month)
      5'h02: begin
        res = (yr_mod == 2'd0) ? 6'h29 : 6'h28;
      end
      5'h04, 5'h06, 5'h09, 5'h11: begin
        res = 6'h30;
      end
      default: begin
        res = 6'h31;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcd_calendar_clock.sv =====
// top level of the bcd calendar clock: input register, set and tick logic, time register
// depends on bcdcal_pkg, bcdcal_set and bcdcal_tick
`default_nettype none

// Takes one word per clock cycle while no result is held back. A word is
// captured in the input register at acceptance; when the time register may
// change, the set normalizer or the one-second incrementer produces the new
// time, which lands in the time register. That register is both the clock's
// state and the result word, so a result is valid from the edge that loads it
// into the time register and stays put until taken. Input ready drops only while a word
// waits behind an untaken result. A set word (op = 1) loads and clamps the new_* bytes;
// a tick word (op = 0) advances one second with carries through weekday, date and year.
module bcd_calendar_clock (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  new_year_i,
  input  logic [7:0]  new_month_i,
  input  logic [7:0]  new_day_i,
  input  logic [7:0]  new_weekday_i,
  input  logic [7:0]  new_hour_i,
  input  logic [7:0]  new_minute_i,
  input  logic [7:0]  new_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  year_out_o,
  output logic [4:0]  month_out_o,
  output logic [5:0]  day_out_o,
  output logic [2:0]  weekday_out_o,
  output logic [5:0]  hour_out_o,
  output logic [6:0]  minute_out_o,
  output logic [6:0]  second_out_o
);
  import bcdcal_pkg::*;

  logic       in_valid_q;
  op_e        op_q;
  logic [7:0] year_q;
  logic [7:0] month_q;
  logic [7:0] day_q;
  logic [7:0] wday_q;
  logic [7:0] hour_q;
  logic [7:0] minute_q;
  logic [7:0] second_q;
  logic       out_valid_q;
  cal_t       cal_q;
  cal_t       cal_d;
  cal_t       set_cal;
  cal_t       tick_cal;
  logic       advance;

  // the time register may change only when its current word is gone or leaving
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_e'(op_i);
      year_q   <= new_year_i;
      month_q  <= new_month_i;
      day_q    <= new_day_i;
      wday_q   <= new_weekday_i;
      hour_q   <= new_hour_i;
      minute_q <= new_minute_i;
      second_q <= new_second_i;
    end
  end

  bcdcal_set u_set (
    .new_year_i    (year_q),
    .new_month_i   (month_q),
    .new_day_i     (day_q),
    .new_weekday_i (wday_q),
    .new_hour_i    (hour_q),
    .new_minute_i  (minute_q),
    .new_second_i  (second_q),
    .cal_o         (set_cal)
  );

  bcdcal_tick u_tick (
    .cal_i (cal_q),
    .cal_o (tick_cal)
  );

  assign cal_d = (op_q == OP_SET) ? set_cal : tick_cal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cal_q       <= CalReset;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        cal_q       <= cal_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign year_out_o    = cal_q.year;
  assign month_out_o   = cal_q.month;
  assign day_out_o     = cal_q.day;
  assign weekday_out_o = cal_q.weekday;
  assign hour_out_o    = cal_q.hour;
  assign minute_out_o  = cal_q.minute;
  assign second_out_o  = cal_q.second;

endmodule

`default_nettype wire

// ===== rtl/core/bcdcal_set.sv =====
// normalizes the seven raw bytes of a set word into a legal date and time
// depends on bcdcal_pkg
`default_nettype none

module bcdcal_set (
  input  logic [7:0]        new_year_i,
  input  logic [7:0]        new_month_i,
  input  logic [7:0]        new_day_i,
  input  logic [7:0]        new_weekday_i,
  input  logic [7:0]        new_hour_i,
  input  logic [7:0]        new_minute_i,
  input  logic [7:0]        new_second_i,
  output bcdcal_pkg::cal_t  cal_o
);
  import bcdcal_pkg::*;

  logic [7:0] year_c;
  logic [7:0] month_c;
  logic [7:0] day_c;
  logic [7:0] wday_c;
  logic [7:0] hour_c;
  logic [7:0] minute_c;
  logic [7:0] second_c;
  logic [5:0] day_max;

  assign year_c   = bcd_clamp(new_year_i, YearMin, YearMax);
  assign month_c  = bcd_clamp(new_month_i, MonthMin, MonthMax);
  // day limit follows the already normalized year and month
  assign day_max  = month_days(year_c, month_c[4:0]);
  assign day_c    = bcd_clamp(new_day_i, DayMin, {2'b00, day_max});
  assign wday_c   = bcd_clamp(new_weekday_i, WdayMin, WdayMax);
  assign hour_c   = bcd_clamp({2'b00, new_hour_i[5:0]}, HourMin, HourMax);
  assign minute_c = bcd_clamp(new_minute_i, MinSecMin, MinSecMax);
  assign second_c = bcd_clamp(new_second_i, MinSecMin, MinSecMax);

  assign cal_o.year    = year_c;
  assign cal_o.month   = month_c[4:0];
  assign cal_o.day     = day_c[5:0];
  assign cal_o.weekday = wday_c[2:0];
  assign cal_o.hour    = hour_c[5:0];
  assign cal_o.minute  = minute_c[6:0];
  assign cal_o.second  = second_c[6:0];

endmodule

`default_nettype wire

// ===== rtl/core/bcdcal_tick.sv =====
// advances a legal date and time by one second with the full carry chain
// depends on bcdcal_pkg
`default_nettype none

module bcdcal_tick (
  input  bcdcal_pkg::cal_t  cal_i,
  output bcdcal_pkg::cal_t  cal_o
);
  import bcdcal_pkg::*;

  logic [7:0] sec_inc;
  logic [7:0] min_inc;
  logic [7:0] hour_inc;
  logic [7:0] day_inc;
  logic [7:0] month_inc;
  logic [7:0] year_inc;
  logic [5:0] day_max;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;

  assign sec_inc   = bcd_inc({1'b0, cal_i.second});
  assign min_inc   = bcd_inc({1'b0, cal_i.minute});
  assign hour_inc  = bcd_inc({2'b00, cal_i.hour});
  assign day_inc   = bcd_inc({2'b00, cal_i.day});
  assign month_inc = bcd_inc({3'b000, cal_i.month});
  assign year_inc  = bcd_inc(cal_i.year);
  assign day_max   = month_days(cal_i.year, cal_i.month);

  assign sec_wrap   = (cal_i.second == MinSecMax[6:0]);
  assign min_wrap   = sec_wrap && (cal_i.minute == MinSecMax[6:0]);
  assign hour_wrap  = min_wrap && (cal_i.hour == HourMax[5:0]);
  assign day_wrap   = hour_wrap && (cal_i.day == day_max);
  assign month_wrap = day_wrap && (cal_i.month == MonthMax[4:0]);

  always_comb begin
    cal_o = cal_i;
    cal_o.second = sec_wrap ? MinSecMin[6:0] : sec_inc[6:0];
    if (sec_wrap) begin
      cal_o.minute = min_wrap ? MinSecMin[6:0] : min_inc[6:0];
    end
    if (min_wrap) begin
      cal_o.hour = hour_wrap ? HourMin[5:0] : hour_inc[5:0];
    end
    if (hour_wrap) begin
      cal_o.weekday = (cal_i.weekday == WdayMax[2:0]) ? WdayMin[2:0] :
                      cal_i.weekday + 3'd1;
      cal_o.day = day_wrap ? DayMin[5:0] : day_inc[5:0];
    end
    if (day_wrap) begin
      cal_o.month = month_wrap ? MonthMin[4:0] : month_inc[4:0];
    end
    if (month_wrap) begin
      cal_o.year = (cal_i.year == YearMax) ? YearMin : year_inc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bcdcal_checker.sv =====
// port-level assertions for the bcd calendar clock and the bind that attaches them
// depends on bcd_calendar_clock
`default_nettype none

module bcdcal_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_ready_o,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  year_out_o,
  input  logic [4:0]  month_out_o,
  input  logic [5:0]  day_out_o,
  input  logic [2:0]  weekday_out_o,
  input  logic [5:0]  hour_out_o,
  input  logic [6:0]  minute_out_o,
  input  logic [6:0]  second_out_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(year_out_o) &&
      $stable(month_out_o) && $stable(day_out_o) && $stable(weekday_out_o) &&
      $stable(hour_out_o) && $stable(minute_out_o) && $stable(second_out_o))
    else $error("result word changed while stalled");

  // input backs up only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // date fields are legal bcd in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_out_o != 5'h00 && month_out_o <= 5'h12 &&
      month_out_o[3:0] <= 4'd9 && day_out_o != 6'h00 && day_out_o <= 6'h31 &&
      day_out_o[3:0] <= 4'd9 && year_out_o[7:4] <= 4'd9 &&
      year_out_o[3:0] <= 4'd9 && weekday_out_o <= 3'd6)
    else $error("illegal date on output");

  // time fields are legal bcd in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hour_out_o <= 6'h23 && hour_out_o[3:0] <= 4'd9 &&
      minute_out_o <= 7'h59 && minute_out_o[3:0] <= 4'd9 &&
      second_out_o <= 7'h59 && second_out_o[3:0] <= 4'd9)
    else $error("illegal time on output");

endmodule

bind bcd_calendar_clock bcdcal_checker u_bcdcal_checker (.*);

`default_nettype wire

// ===== tb/bcd_calendar_clock_tb.sv =====
// self-checking testbench for the bcd calendar clock: directed and random set/tick words
// depends on bcdcal_pkg and the bcd_calendar_clock rtl
`timescale 1ns / 100ps

module bcd_calendar_clock_tb;
  import bcdcal_pkg::*;

  typedef struct {
    op_e        op;
    logic [7:0] yr;
    logic [7:0] mo;
    logic [7:0] dy;
    logic [7:0] wd;
    logic [7:0] hr;
    logic [7:0] mi;
    logic [7:0] sc;
  } word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       op_i = 1'b0;
  logic [7:0] new_year_i = 8'h00;
  logic [7:0] new_month_i = 8'h00;
  logic [7:0] new_day_i = 8'h00;
  logic [7:0] new_weekday_i = 8'h00;
  logic [7:0] new_hour_i = 8'h00;
  logic [7:0] new_minute_i = 8'h00;
  logic [7:0] new_second_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] year_out_o;
  logic [4:0] month_out_o;
  logic [5:0] day_out_o;
  logic [2:0] weekday_out_o;
  logic [5:0] hour_out_o;
  logic [6:0] minute_out_o;
  logic [6:0] second_out_o;

  word_t word_q[$];
  cal_t  times_due[$];
  cal_t  shadow_time = CalReset;
  int    send_idle_pct = 21;
  int    recv_idle_pct = 70;
  int    mismatches = 0;

  bcd_calendar_clock DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .new_year_i,
    .new_month_i,
    .new_day_i,
    .new_weekday_i,
    .new_hour_i,
    .new_minute_i,
    .new_second_i,
    .out_valid_o,
    .out_ready_i,
    .year_out_o,
    .month_out_o,
    .day_out_o,
    .weekday_out_o,
    .hour_out_o,
    .minute_out_o,
    .second_out_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [7:0] to_bcd(input int v);
    logic [7:0] b;
    b[7:4] = 4'(v / 10);
    b[3:0] = 4'(v % 10);
    return b;
  endfunction

  // decode a raw bcd byte into binary; bad nibble gives hi, else clamp to [lo, hi]
  function automatic int decode_clamp(input logic [7:0] raw, input int lo, input int hi);
    int v;
    if (raw[7:4] > 4'd9 || raw[3:0] > 4'd9) begin
      return hi;
    end
    v = raw[7:4] * 10 + raw[3:0];
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic int days_in(input int year, input int month);
    int n;
    case (month)
      2: begin
        n = (year % 4 == 0) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        n = 30;
      end
      default: begin
        n = 31;
      end
    endcase
    return n;
  endfunction

  // time after one word: set normalizes the raw bytes, tick renormalizes and adds a second
  function automatic cal_t next_time(input cal_t cur, input logic op, input word_t w);
    int         y, m, d, wd, h, mi, s;
    logic [7:0] src[7];
    logic [7:0] b;
    cal_t       res;
    if (op == OP_SET) begin
      src = '{w.yr, w.mo, w.dy, w.wd, w.hr, w.mi, w.sc};
    end else begin
      src = '{cur.year, {3'b0, cur.month}, {2'b0, cur.day}, {5'b0, cur.weekday},
              {2'b0, cur.hour}, {1'b0, cur.minute}, {1'b0, cur.second}};
    end
    y  = decode_clamp(src[0], 0, 99);
    m  = decode_clamp(src[1], 1, 12);
    d  = decode_clamp(src[2], 1, days_in(y, m));
    wd = decode_clamp(src[3], 0, 6);
    h  = decode_clamp(src[4] & 8'h3F, 0, 23);
    mi = decode_clamp(src[5], 0, 59);
    s  = decode_clamp(src[6], 0, 59);
    if (op != OP_SET) begin
      s++;
      if (s >= 60) begin
        s = 0;
        mi++;
        if (mi >= 60) begin
          mi = 0;
          h++;
          if (h >= 24) begin
            h = 0;
            wd = (wd + 1) % 7;
            d++;
            if (d > days_in(y, m)) begin
              d = 1;
              m++;
              if (m > 12) begin
                m = 1;
                y = (y + 1) % 100;
              end
            end
          end
        end
      end
    end
    res.year = to_bcd(y);
    b = to_bcd(m);
    res.month = b[4:0];
    b = to_bcd(d);
    res.day = b[5:0];
    res.weekday = wd[2:0];
    b = to_bcd(h);
    res.hour = b[5:0];
    b = to_bcd(mi);
    res.minute = b[6:0];
    b = to_bcd(s);
    res.second = b[6:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  always @(posedge clk_i) begin : word_driver
    word_t nxt;
    word_t held;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        held = '{op_e'(op_i), new_year_i, new_month_i, new_day_i, new_weekday_i,
                 new_hour_i, new_minute_i, new_second_i};
        shadow_time = next_time(shadow_time, op_i, held);
        times_due.push_back(shadow_time);
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = word_q.pop_front();
          in_valid_i    <= 1'b1;
          op_i          <= nxt.op;
          new_year_i    <= nxt.yr;
          new_month_i   <= nxt.mo;
          new_day_i     <= nxt.dy;
          new_weekday_i <= nxt.wd;
          new_hour_i    <= nxt.hr;
          new_minute_i  <= nxt.mi;
          new_second_i  <= nxt.sc;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string what, input int exp_val, input int got_val);
    mismatches++;
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
             $time, what, exp_val, got_val);
  endtask

  always @(posedge clk_i) begin : result_monitor
    cal_t due;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (times_due.size() == 0) begin
          report("result word with nothing pending", 0, 0);
        end else begin
          due = times_due.pop_front();
          if (year_out_o !== due.year) report("year", due.year, year_out_o);
          if (month_out_o !== due.month) report("month", due.month, month_out_o);
          if (day_out_o !== due.day) report("day", due.day, day_out_o);
          if (weekday_out_o !== due.weekday) report("weekday", due.weekday, weekday_out_o);
          if (hour_out_o !== due.hour) report("hour", due.hour, hour_out_o);
          if (minute_out_o !== due.minute) report("minute", due.minute, minute_out_o);
          if (second_out_o !== due.second) report("second", due.second, second_out_o);
        end
      end
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_set(input logic [7:0] y, mo, d, wd, h, mi, s);
    word_q.push_back('{OP_SET, y, mo, d, wd, h, mi, s});
  endtask

  task automatic push_tick(input int n);
    repeat (n) word_q.push_back('{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
  endtask

  task automatic queue_random(input int count);
    int target;
    int y, m, d;
    target = word_q.size() + count;
    while (word_q.size() < target) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: begin
          // time near a rollover (the day may pass the month end), then one to twelve ticks that may carry through it
          y = $urandom_range(99, 0);
          m = $urandom_range(12, 1);
          if ($urandom_range(7, 0) == 0) begin
            y = 99;
            m = 12;
          end
          d = $urandom_range(1, 0) ? days_in(y, m) : $urandom_range(31, 1);
          push_set(to_bcd(y), to_bcd(m), to_bcd(d), to_bcd($urandom_range(6, 0)),
                   $urandom_range(3, 0) != 0 ? 8'h23 : to_bcd($urandom_range(23, 0)),
                   $urandom_range(3, 0) != 0 ? 8'h59 : to_bcd($urandom_range(59, 0)),
                   to_bcd($urandom_range(59, 50)));
          push_tick($urandom_range(12, 1));
        end
        4, 5, 6: begin
          push_tick($urandom_range(5, 1));
        end
        7, 8: begin
          push_set(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                   8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                   8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                   8'($urandom_range(255, 0)));
        end
        default: begin
          y = $urandom_range(99, 0);
          m = $urandom_range(12, 1);
          push_set(to_bcd(y), to_bcd(m), to_bcd($urandom_range(days_in(y, m), 1)),
                   to_bcd($urandom_range(6, 0)), to_bcd($urandom_range(23, 0)),
                   to_bcd($urandom_range(59, 0)), to_bcd($urandom_range(59, 0)));
        end
      endcase
    end
  endtask

  // checked away from the rising edge so driver and monitor updates have settled
  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid_i || times_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words
    push_tick(1);                                                // first tick out of reset
    push_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // below minimums
    push_set(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);   // bad nibbles everywhere
    push_tick(1);                                                // year 99 wraps to 00
    push_set(8'h00, 8'h13, 8'h32, 8'h07, 8'h24, 8'h60, 8'h60);   // above maximums
    push_set(8'h9A, 8'h1A, 8'hA1, 8'h1A, 8'hC5, 8'h5F, 8'hF5);   // mixed bad nibbles, hour top bits
    push_set(8'h45, 8'h06, 8'h15, 8'h09, 8'h80, 8'h30, 8'h00);   // weekday 9, hour top bit only
    push_set(8'h24, 8'h02, 8'h30, 8'h03, 8'h12, 8'h00, 8'h00);   // leap feb clamps to 29
    push_set(8'h23, 8'h02, 8'h29, 8'h03, 8'h12, 8'h00, 8'h00);   // common feb clamps to 28
    push_set(8'h24, 8'h02, 8'h28, 8'h05, 8'h23, 8'h59, 8'h59);   // leap feb 28 -> 29
    push_tick(1);
    push_set(8'h00, 8'h02, 8'h29, 8'h06, 8'h23, 8'h59, 8'h59);   // leap feb 29 -> mar 1
    push_tick(1);
    push_set(8'h23, 8'h02, 8'h28, 8'h02, 8'h23, 8'h59, 8'h59);   // common feb 28 -> mar 1
    push_tick(1);
    push_set(8'h50, 8'h04, 8'h31, 8'h04, 8'h23, 8'h59, 8'h59);   // april 31 clamps, then may 1
    push_tick(1);
    push_set(8'h10, 8'h07, 8'h15, 8'h01, 8'h09, 8'h59, 8'h59);   // hour carry 09 -> 10
    push_tick(1);
    push_set(8'h10, 8'h07, 8'h15, 8'h01, 8'h19, 8'h29, 8'h59);   // minute carry only
    push_tick(2);
    queue_random(600);
    wait_drained();

    // sender holds off until everything has drained, then swaps the idle ratios
    send_idle_pct = 70;
    recv_idle_pct = 21;
    queue_random(600);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(600);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (times_due.size() != 0) begin
      report("results never delivered", times_due.size(), 0);
    end
    if (mismatches == 0) begin
      $display("bcd_calendar_clock_tb passed");
    end else begin
      $display("bcd_calendar_clock_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bcd_calendar_clock_tb failed");
    $finish;
  end

endmodule

// ===== bcd_calendar_clock.f =====
rtl/core/bcdcal_pkg.sv
rtl/core/bcdcal_set.sv
rtl/core/bcdcal_tick.sv
rtl/core/bcd_calendar_clock.sv
rtl/core/bcdcal_checker.sv
tb/bcd_calendar_clock_tb.sv
